### src/tsphk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsphk_pkg
// Shared types and constants of the Held-Karp tour solver.
// ----------------------------------------------------------------------------
package tsphk_pkg;

  // Tour length width and its saturation value
  localparam int          LEN_W   = 20;
  localparam logic [19:0] LEN_MAX = 20'hFFFFF;

  // Field widths fixed by the port list
  localparam int CITY_W = 3;
  localparam int CFG_W  = 4;

  // City count after reset
  localparam logic [3:0] CITY_COUNT_RESET = 4'd8;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE_RD,
    ST_BASE_WR,
    ST_DP_I,
    ST_DP_J,
    ST_DP_ACC,
    ST_DP_WR,
    ST_FIN_J,
    ST_FIN_ACC,
    ST_FIN_WR,
    ST_WALK_OUT,
    ST_WALK_RD
  } tsphk_state_t;

endpackage

### src/tsp_held_karp_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_held_karp_solver
// Held-Karp solver: loads a distance matrix, runs the subset dynamic program
// on one shared saturating adder and comparator, then emits the tour.
// ----------------------------------------------------------------------------
// Matrix entries are taken one per clock while busy is low. The entry with
// in_last_entry set is stored and then starts the solve; busy stays high until
// the last tour city has been shown. The solve runs on a single saturating
// adder/comparator and the one read port of the cost table, so each candidate
// predecessor takes a table read, then an add and compare. The base costs come
// first. Every subset other than the empty and the full one then skips each
// end city inside it and searches the predecessors of each end city outside
// it. The closing leg follows, and the tour for n cities then comes out as
// n-1 results, each shown on the out_ ports for a single cycle under
// out_valid. The city count register is written only while busy is low. The
// receiver cannot stall the block, so it must take every result as it
// appears.
module tsp_held_karp_solver #(
  parameter int MAX_CITIES    = 8,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Matrix entry input
  input  logic                          start,
  output logic                          busy,
  input  logic [tsphk_pkg::CITY_W-1:0]  in_from_city,
  input  logic [tsphk_pkg::CITY_W-1:0]  in_to_city,
  input  logic [15:0]                   in_distance,
  input  logic                          in_last_entry,
  // Tour output
  output logic                          out_valid,
  output logic [tsphk_pkg::LEN_W-1:0]   out_tour_length,
  output logic [tsphk_pkg::CITY_W-1:0]  out_tour_position,
  output logic [tsphk_pkg::CITY_W-1:0]  out_tour_city,
  output logic                          out_last_city,
  // City count register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsphk_pkg::CFG_W-1:0]   cfg_data
);
  import tsphk_pkg::*;

  localparam int CW   = $clog2(MAX_CITIES);
  localparam int SW   = MAX_CITIES - 1;
  localparam int TW   = CW + LEN_W;
  localparam int SUMW = ((DISTANCE_BITS > LEN_W) ? DISTANCE_BITS : LEN_W) + 1;

  // Storage
  logic [DISTANCE_BITS-1:0] dist_mem [MAX_CITIES][MAX_CITIES];
  logic [MAX_CITIES-1:0]    dist_vld_r [MAX_CITIES];
  logic [TW-1:0]            tbl_mem [MAX_CITIES * (2 ** SW)];

  // Control and datapath registers
  tsphk_state_t       st_r, st_nxt;
  logic [CFG_W-1:0]   city_cnt_r;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic [SW-1:0]      ind_r, ind_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      city_r, city_nxt;
  logic               found_r, found_nxt;
  logic [LEN_W-1:0]   bd_r, bd_nxt;
  logic [CW-1:0]      bp_r, bp_nxt;
  logic [LEN_W-1:0]   best_r, best_nxt;

  // Memory read data
  logic [DISTANCE_BITS-1:0] dist_rd_r;
  logic                     dist_rd_vld_r;
  logic [TW-1:0]            tbl_rd_r;

  // Combinational helpers
  logic [CW-1:0]            nm1;
  logic [SW-1:0]            full;
  logic [SW-1:0]            im, jm, cm;
  logic                     city_ok;
  logic                     adv_i;
  logic [DISTANCE_BITS+15:0] dist_ext;
  logic                     dist_we;
  logic [CW-1:0]            dw_row, dw_col;
  logic [CW-1:0]            dr_row, dr_col;
  logic [CW+SW-1:0]         tbl_raddr, tbl_waddr;
  logic                     tbl_we;
  logic [TW-1:0]            tbl_wdata;
  logic [LEN_W-1:0]         cost_op;
  logic [DISTANCE_BITS-1:0] dist_op;
  logic [SUMW-1:0]          sum;
  logic [LEN_W-1:0]         d_sat;
  logic                     upd;

  // Clamp the city count and form the full subset mask
  always_comb begin
    if (city_cnt_r < 4'd2) begin
      nm1 = CW'(1);
    end else if (int'(city_cnt_r) > MAX_CITIES) begin
      nm1 = CW'(MAX_CITIES - 1);
    end else begin
      nm1 = CW'(city_cnt_r - 4'd1);
    end
  end

  assign full    = ~({SW{1'b1}} << nm1);
  assign im      = SW'(1) << (i_r - CW'(1));
  assign jm      = SW'(1) << (j_r - CW'(1));
  assign cm      = SW'(1) << (city_r - CW'(1));
  assign city_ok = (city_r != '0) && (city_r <= nm1);

  // Shared saturating adder and comparator
  assign dist_op = dist_rd_vld_r ? dist_rd_r : '0;
  assign cost_op = (st_r == ST_BASE_WR) ? '0 : tbl_rd_r[LEN_W-1:0];
  assign sum     = SUMW'(dist_op) + SUMW'(cost_op);
  assign d_sat   = (sum > SUMW'(LEN_MAX)) ? LEN_MAX : sum[LEN_W-1:0];
  assign upd     = !found_r || (d_sat < bd_r);

  // Configuration register: hold writes off while a solve is running
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_cnt_r <= CITY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      city_cnt_r <= cfg_data;
    end
  end

  // Distance store write: drop entries beyond the built maximum
  assign dist_ext = {DISTANCE_BITS'(0), in_distance};
  assign dist_we  = start && !busy && (int'(in_from_city) < MAX_CITIES)
                    && (int'(in_to_city) < MAX_CITIES);
  assign dw_row   = CW'(in_from_city);
  assign dw_col   = CW'(in_to_city);

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dw_row][dw_col] <= dist_ext[DISTANCE_BITS-1:0];
    end
    dist_rd_r <= dist_mem[dr_row][dr_col];
  end

  // Valid bits: entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_CITIES; r++) begin
        dist_vld_r[r] <= '0;
      end
      dist_rd_vld_r <= 1'b0;
    end else begin
      if (dist_we) begin
        dist_vld_r[dw_row][dw_col] <= 1'b1;
      end
      dist_rd_vld_r <= dist_vld_r[dr_row][dr_col];
    end
  end

  // Cost and predecessor table
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      s_r     <= '0;
      ind_r   <= '0;
      pos_r   <= '0;
      city_r  <= '0;
      found_r <= 1'b0;
      best_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      s_r     <= s_nxt;
      ind_r   <= ind_nxt;
      pos_r   <= pos_nxt;
      city_r  <= city_nxt;
      found_r <= found_nxt;
      best_r  <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bd_r <= bd_nxt;
    bp_r <= bp_nxt;
  end

  // Next state and counters
  always_comb begin
    st_nxt    = st_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    s_nxt     = s_r;
    ind_nxt   = ind_r;
    pos_nxt   = pos_r;
    city_nxt  = city_r;
    found_nxt = found_r;
    bd_nxt    = bd_r;
    bp_nxt    = bp_r;
    best_nxt  = best_r;
    adv_i     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (start && in_last_entry) begin
          i_nxt  = CW'(1);
          st_nxt = ST_BASE_RD;
        end
      end
      ST_BASE_RD: begin
        st_nxt = ST_BASE_WR;
      end
      ST_BASE_WR: begin
        if (i_r == nm1) begin
          if (nm1 == CW'(1)) begin
            j_nxt     = CW'(1);
            found_nxt = 1'b0;
            st_nxt    = ST_FIN_J;
          end else begin
            s_nxt  = SW'(1);
            i_nxt  = CW'(1);
            st_nxt = ST_DP_I;
          end
        end else begin
          i_nxt  = i_r + CW'(1);
          st_nxt = ST_BASE_RD;
        end
      end
      ST_DP_I: begin
        if (|(s_r & im)) begin
          adv_i = 1'b1;
        end else begin
          j_nxt     = CW'(1);
          found_nxt = 1'b0;
          st_nxt    = ST_DP_J;
        end
      end
      ST_DP_J: begin
        if (|(s_r & jm)) begin
          st_nxt = ST_DP_ACC;
        end else if (j_r == nm1) begin
          st_nxt = ST_DP_WR;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      ST_DP_ACC: begin
        if (upd) begin
          found_nxt = 1'b1;
          bd_nxt    = d_sat;
          bp_nxt    = j_r;
        end
        if (j_r == nm1) begin
          st_nxt = ST_DP_WR;
        end else begin
          j_nxt  = j_r + CW'(1);
          st_nxt = ST_DP_J;
        end
      end
      ST_DP_WR: begin
        adv_i = 1'b1;
      end
      ST_FIN_J: begin
        st_nxt = ST_FIN_ACC;
      end
      ST_FIN_ACC: begin
        if (upd) begin
          found_nxt = 1'b1;
          bd_nxt    = d_sat;
          bp_nxt    = j_r;
        end
        if (j_r == nm1) begin
          st_nxt = ST_FIN_WR;
        end else begin
          j_nxt  = j_r + CW'(1);
          st_nxt = ST_FIN_J;
        end
      end
      ST_FIN_WR: begin
        best_nxt = bd_r;
        city_nxt = bp_r;
        ind_nxt  = full;
        pos_nxt  = CW'(1);
        st_nxt   = ST_WALK_OUT;
      end
      ST_WALK_OUT: begin
        if (pos_r == nm1) begin
          st_nxt = ST_IDLE;
        end else if (city_ok) begin
          ind_nxt = ind_r & ~cm;
          st_nxt  = ST_WALK_RD;
        end else begin
          pos_nxt = pos_r + CW'(1);
        end
      end
      ST_WALK_RD: begin
        city_nxt = tbl_rd_r[LEN_W +: CW];
        pos_nxt  = pos_r + CW'(1);
        st_nxt   = ST_WALK_OUT;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // Advance to the next end city, then to the next subset
    if (adv_i) begin
      if (i_r == nm1) begin
        if (s_r == full - SW'(1)) begin
          j_nxt     = CW'(1);
          found_nxt = 1'b0;
          st_nxt    = ST_FIN_J;
        end else begin
          s_nxt  = s_r + SW'(1);
          i_nxt  = CW'(1);
          st_nxt = ST_DP_I;
        end
      end else begin
        i_nxt  = i_r + CW'(1);
        st_nxt = ST_DP_I;
      end
    end
  end

  // Outputs and memory control
  always_comb begin
    busy      = (st_r != ST_IDLE);
    out_valid = (st_r == ST_WALK_OUT);
    dr_row    = i_r;
    dr_col    = j_r;
    tbl_raddr = {city_r, ind_r & ~cm};
    tbl_we    = 1'b0;
    tbl_waddr = {i_r, s_r};
    tbl_wdata = {bp_r, bd_r};
    case (st_r)
      ST_BASE_RD: begin
        dr_col = '0;
      end
      ST_BASE_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {i_r, SW'(0)};
        tbl_wdata = {CW'(0), d_sat};
      end
      ST_DP_J: begin
        tbl_raddr = {j_r, s_r & ~jm};
      end
      ST_DP_WR: begin
        tbl_we = 1'b1;
      end
      ST_FIN_J: begin
        dr_row    = '0;
        tbl_raddr = {j_r, full & ~jm};
      end
      ST_FIN_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {CW'(0), full};
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  assign out_tour_length   = best_r;
  assign out_tour_position = CITY_W'(pos_r);
  assign out_tour_city     = CITY_W'(city_r);
  assign out_last_city     = (pos_r == nm1);

`ifndef SYNTHESIS
  // A solve starts on the last entry
  a_solve_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_entry |=> busy)
    else $error("solve did not start on last entry");

  // A plain entry leaves the block idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_entry |=> !busy)
    else $error("plain entry made block busy");

  // The final city ends the solve
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_city |=> !busy && !out_valid)
    else $error("block busy after last tour city");

  // Results only while busy and with a real step number
  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy && (out_tour_position != '0))
    else $error("bad tour result");
`endif

endmodule
